/* src/ers_pkg.sv */
`default_nettype none
package ers_pkg;

  // width of each configuration register and of the setting fields
  localparam int REG_W = 16;

  // configuration register file
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_DIST_MIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIST_MAX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT_MIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COUNT_MAX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_TMO  = 3'd4;

  // reset values of the configuration registers
  localparam logic [REG_W-1:0] RST_DIST_MIN  = 16'd0;
  localparam logic [REG_W-1:0] RST_DIST_MAX  = 16'hFFFF;
  localparam logic [REG_W-1:0] RST_COUNT_MIN = 16'd1;
  localparam logic [REG_W-1:0] RST_COUNT_MAX = 16'hFFFF;
  localparam logic [REG_W-1:0] RST_IDLE_TMO  = 16'd600;

  // saturation limit of the point and idle counters
  localparam logic [REG_W-1:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [REG_W-1:0] distance_min;
    logic [REG_W-1:0] distance_max;
    logic [REG_W-1:0] count_min;
    logic [REG_W-1:0] count_max;
    logic [REG_W-1:0] idle_timeout;
  } cfg_t;

  // run mode, one-hot
  typedef enum logic [4:0] {
    MODE_RESET      = 5'b00001,
    MODE_STOPPED    = 5'b00010,
    MODE_CONFIGURED = 5'b00100,
    MODE_STARTED    = 5'b01000,
    MODE_SENDING    = 5'b10000
  } mode_t;

  // external mode codes
  localparam logic [2:0] CODE_RESET      = 3'd0;
  localparam logic [2:0] CODE_STOPPED    = 3'd1;
  localparam logic [2:0] CODE_CONFIGURED = 3'd2;
  localparam logic [2:0] CODE_STARTED    = 3'd3;
  localparam logic [2:0] CODE_SENDING    = 3'd4;

  // input commands
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_POLL     = 3'd1;
  localparam logic [2:0] CMD_REQUEST  = 3'd2;
  localparam logic [2:0] CMD_WR_DIST  = 3'd3;
  localparam logic [2:0] CMD_WR_COUNT = 3'd4;
  localparam logic [2:0] CMD_IDENTITY = 3'd5;

  // entry actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_RESET     = 3'd1;
  localparam logic [2:0] ACT_STOP      = 3'd2;
  localparam logic [2:0] ACT_CONFIGURE = 3'd3;
  localparam logic [2:0] ACT_START     = 3'd4;

  // one-hot mode to external code
  function automatic logic [2:0] mode_to_code(input mode_t m);
    logic [2:0] c;
    case (m)
      MODE_RESET:      c = CODE_RESET;
      MODE_STOPPED:    c = CODE_STOPPED;
      MODE_CONFIGURED: c = CODE_CONFIGURED;
      MODE_STARTED:    c = CODE_STARTED;
      MODE_SENDING:    c = CODE_SENDING;
      default:         c = CODE_RESET;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* src/ers_if.sv */
`default_nettype none
// input word channel
interface ers_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [2:0]  target_mode;
  logic        echo_request;
  logic [15:0] write_value;
  logic        point_ready;
  logic        ball_halted;

  modport source (
    output valid, command, target_mode, echo_request, write_value, point_ready,
           ball_halted,
    input  ready
  );
  modport sink (
    input  valid, command, target_mode, echo_request, write_value, point_ready,
           ball_halted,
    output ready
  );
endinterface

// result word channel
interface ers_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode_now;
  logic [2:0]  entry_action;
  logic [15:0] launch_distance;
  logic        lamp_on;
  logic        point_emitted;
  logic [15:0] point_number;
  logic        run_ended;
  logic        identity_due;
  logic        echo_ack;
  logic        request_taken;
  logic [31:0] uptime_seconds;

  modport source (
    output valid, mode_now, entry_action, launch_distance, lamp_on, point_emitted,
           point_number, run_ended, identity_due, echo_ack, request_taken,
           uptime_seconds,
    input  ready
  );
  modport sink (
    input  valid, mode_now, entry_action, launch_distance, lamp_on, point_emitted,
           point_number, run_ended, identity_due, echo_ack, request_taken,
           uptime_seconds,
    output ready
  );
endinterface
`default_nettype wire

/* src/ers_cfg_regs.sv */
`default_nettype none
module ers_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ers_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ers_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ers_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output ers_pkg::cfg_t                      cfg
);

  ers_pkg::cfg_t cfg_r;
  logic [ers_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;
  logic [ers_pkg::REG_W-1:0] rd_val;

  // word index from the byte address
  assign idx    = paddr[ers_pkg::PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.distance_min <= ers_pkg::RST_DIST_MIN;
      cfg_r.distance_max <= ers_pkg::RST_DIST_MAX;
      cfg_r.count_min    <= ers_pkg::RST_COUNT_MIN;
      cfg_r.count_max    <= ers_pkg::RST_COUNT_MAX;
      cfg_r.idle_timeout <= ers_pkg::RST_IDLE_TMO;
    end else if (wr_en) begin
      case (idx)
        ers_pkg::REG_DIST_MIN:  cfg_r.distance_min <= pwdata[ers_pkg::REG_W-1:0];
        ers_pkg::REG_DIST_MAX:  cfg_r.distance_max <= pwdata[ers_pkg::REG_W-1:0];
        ers_pkg::REG_COUNT_MIN: cfg_r.count_min    <= pwdata[ers_pkg::REG_W-1:0];
        ers_pkg::REG_COUNT_MAX: cfg_r.count_max    <= pwdata[ers_pkg::REG_W-1:0];
        ers_pkg::REG_IDLE_TMO:  cfg_r.idle_timeout <= pwdata[ers_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      ers_pkg::REG_DIST_MIN:  rd_val = cfg_r.distance_min;
      ers_pkg::REG_DIST_MAX:  rd_val = cfg_r.distance_max;
      ers_pkg::REG_COUNT_MIN: rd_val = cfg_r.count_min;
      ers_pkg::REG_COUNT_MAX: rd_val = cfg_r.count_max;
      ers_pkg::REG_IDLE_TMO:  rd_val = cfg_r.idle_timeout;
      default:                rd_val = '0;
    endcase
    prdata = ers_pkg::PDATA_W'(rd_val);
  end

endmodule
`default_nettype wire

/* src/experiment_run_sequencer.sv */
// Run sequencer for a launched-ball oscillation experiment.
// in_word carries one command per word: half-second tick, main-loop poll
// (with point-ready and ball-halted flags), guarded mode request, setting
// write or identity schedule. out_word returns exactly one result word per
// input word: mode, entry action, launch distance, lamp, point report,
// run end, identity and echo flags, request status and uptime seconds.
// The user writes registers over the cfg_ APB port only while no word is in
// flight; the block does not enforce it. A word's result is registered and
// shows from the next cycle on. Throughput is one word per cycle unless
// stalled; a single combinational pass feeds the state and result registers.
// in_word.ready is high while the result register is empty or being drained
// in the same cycle, so a stalled receiver holds the result and stops intake
// only once that register is full.
// After reset the mode is reset with its entry pending, all counters are
// zero and the registers hold their reset values.
`default_nettype none
module experiment_run_sequencer #(
  parameter int SETTING_WIDTH = 16,
  parameter int UPTIME_WIDTH  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ers_in_if.sink                             in_word,
  ers_out_if.source                          out_word,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ers_pkg::PADDR_W-1:0]   cfg_paddr,
  input  wire logic [ers_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic      [ers_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  localparam int CW = (SETTING_WIDTH > ers_pkg::REG_W) ? SETTING_WIDTH : ers_pkg::REG_W;

  typedef struct packed {
    logic [2:0]  mode_now;
    logic [2:0]  entry_action;
    logic [15:0] launch_distance;
    logic        lamp_on;
    logic        point_emitted;
    logic [15:0] point_number;
    logic        run_ended;
    logic        identity_due;
    logic        echo_ack;
    logic        request_taken;
    logic [31:0] uptime_seconds;
  } res_t;

  ers_pkg::cfg_t cfg;

  // state
  ers_pkg::mode_t             mode_r, mode_nxt;
  logic                       pend_r, pend_nxt;
  logic                       echo_r, echo_nxt;
  logic [SETTING_WIDTH-1:0]   dist_r, dist_nxt;
  logic [SETTING_WIDTH-1:0]   count_r, count_nxt;
  logic [ers_pkg::REG_W-1:0]  points_r, points_nxt;
  logic [ers_pkg::REG_W-1:0]  idle_r, idle_nxt;
  logic                       phase_r, phase_nxt;
  logic [1:0]                 div_r, div_nxt;
  logic                       idp_r, idp_nxt;
  logic [UPTIME_WIDTH-1:0]    up_r, up_nxt;
  logic                       lamp_r, lamp_nxt;

  res_t res_r, res_nxt;
  logic out_valid_r;
  logic accept;

  // temporaries of the update pass
  logic [ers_pkg::REG_W-1:0] idle_t;
  logic [ers_pkg::REG_W-1:0] pts_t;
  logic                      set_ok;
  logic                      pass;
  ers_pkg::mode_t            tgt;

  ers_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // handshake: result register frees as it drains
  assign in_word.ready = ~out_valid_r | out_word.ready;
  assign accept        = in_word.valid & in_word.ready;

  // settings inside the configured window
  assign set_ok = (CW'(dist_r) >= CW'(cfg.distance_min)) &&
                  (CW'(dist_r) <= CW'(cfg.distance_max)) &&
                  (CW'(count_r) >= CW'(cfg.count_min)) &&
                  (CW'(count_r) <= CW'(cfg.count_max));

  // next state and result for one word
  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    echo_nxt   = echo_r;
    dist_nxt   = dist_r;
    count_nxt  = count_r;
    points_nxt = points_r;
    idle_nxt   = idle_r;
    phase_nxt  = phase_r;
    div_nxt    = div_r;
    idp_nxt    = idp_r;
    up_nxt     = up_r;
    lamp_nxt   = lamp_r;
    res_nxt    = '0;
    idle_t     = idle_r;
    pts_t      = points_r;
    pass       = 1'b0;
    tgt        = ers_pkg::MODE_RESET;

    case (in_word.command)
      ers_pkg::CMD_TICK: begin
        phase_nxt = ~phase_r;
        div_nxt   = div_r + 2'd1;
        // second boundary on every other tick
        if (phase_r) begin
          if (idle_r != ers_pkg::CNT_MAX) begin
            idle_t = idle_r + 16'd1;
          end
          up_nxt = up_r + UPTIME_WIDTH'(1);
        end
        idle_nxt = idle_t;
        // idle timeout falls back to stopped
        if (idle_t == cfg.idle_timeout &&
            (mode_r == ers_pkg::MODE_CONFIGURED || mode_r == ers_pkg::MODE_STARTED)) begin
          idle_nxt = '0;
          echo_nxt = 1'b0;
          mode_nxt = ers_pkg::MODE_STOPPED;
          pend_nxt = 1'b1;
        end
        if (div_nxt == 2'd0 && mode_r != ers_pkg::MODE_SENDING) begin
          idp_nxt = 1'b1;
        end
      end

      ers_pkg::CMD_POLL: begin
        // identity message outside sending
        if (idp_r && mode_r != ers_pkg::MODE_SENDING) begin
          div_nxt = '0;
          idp_nxt = 1'b0;
          res_nxt.identity_due = 1'b1;
        end
        pend_nxt = 1'b0;
        if (mode_r == ers_pkg::MODE_SENDING) begin
          // point report
          if (in_word.point_ready) begin
            if (points_r != ers_pkg::CNT_MAX) begin
              pts_t = points_r + 16'd1;
            end
            idle_nxt = '0;
            res_nxt.point_emitted = 1'b1;
            res_nxt.point_number  = pts_t;
          end
          points_nxt = pts_t;
          // run end
          if (in_word.ball_halted || CW'(pts_t) == CW'(count_r)) begin
            res_nxt.run_ended = 1'b1;
            div_nxt  = '0;
            idp_nxt  = 1'b0;
            idle_nxt = '0;
            echo_nxt = 1'b0;
            mode_nxt = ers_pkg::MODE_STOPPED;
            pend_nxt = 1'b1;
          end
        end else if (pend_r) begin
          // pending entry actions
          idle_nxt = '0;
          case (mode_r)
            ers_pkg::MODE_RESET: begin
              points_nxt = '0;
              lamp_nxt   = 1'b0;
              dist_nxt   = '0;
              count_nxt  = '0;
              res_nxt.entry_action = ers_pkg::ACT_RESET;
            end
            ers_pkg::MODE_STOPPED: begin
              points_nxt = '0;
              lamp_nxt   = 1'b0;
              res_nxt.entry_action = ers_pkg::ACT_STOP;
            end
            ers_pkg::MODE_CONFIGURED: begin
              lamp_nxt = 1'b1;
              res_nxt.entry_action = ers_pkg::ACT_CONFIGURE;
            end
            ers_pkg::MODE_STARTED: begin
              points_nxt = '0;
              res_nxt.entry_action    = ers_pkg::ACT_START;
              res_nxt.launch_distance = 16'(dist_r);
            end
            default: ;
          endcase
          if (echo_r) begin
            res_nxt.echo_ack = 1'b1;
            div_nxt = '0;
            idp_nxt = 1'b0;
          end
          // start entry moves straight on to sending
          if (mode_r == ers_pkg::MODE_STARTED) begin
            echo_nxt = 1'b0;
            mode_nxt = ers_pkg::MODE_SENDING;
            pend_nxt = 1'b1;
          end
        end
      end

      ers_pkg::CMD_REQUEST: begin
        echo_nxt = in_word.echo_request;
        if (in_word.echo_request) begin
          div_nxt = '0;
          idp_nxt = 1'b0;
        end
        // mode guards
        case (in_word.target_mode)
          ers_pkg::CODE_RESET: begin
            tgt  = ers_pkg::MODE_RESET;
            pass = 1'b1;
          end
          ers_pkg::CODE_STOPPED: begin
            tgt  = ers_pkg::MODE_STOPPED;
            pass = 1'b1;
          end
          ers_pkg::CODE_CONFIGURED: begin
            tgt  = ers_pkg::MODE_CONFIGURED;
            pass = (mode_r != ers_pkg::MODE_SENDING) && set_ok;
          end
          ers_pkg::CODE_STARTED: begin
            tgt  = ers_pkg::MODE_STARTED;
            pass = (mode_r == ers_pkg::MODE_CONFIGURED) && set_ok;
          end
          ers_pkg::CODE_SENDING: begin
            tgt  = ers_pkg::MODE_SENDING;
            pass = (mode_r == ers_pkg::MODE_STARTED);
          end
          default: ;
        endcase
        if (pass) begin
          mode_nxt = tgt;
          pend_nxt = 1'b1;
          res_nxt.request_taken = 1'b1;
        end
      end

      ers_pkg::CMD_WR_DIST:  dist_nxt  = SETTING_WIDTH'(in_word.write_value);
      ers_pkg::CMD_WR_COUNT: count_nxt = SETTING_WIDTH'(in_word.write_value);
      ers_pkg::CMD_IDENTITY: idp_nxt   = 1'b1;
      default: ;
    endcase

    res_nxt.mode_now       = ers_pkg::mode_to_code(mode_nxt);
    res_nxt.lamp_on        = lamp_nxt;
    res_nxt.uptime_seconds = 32'(up_nxt);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ers_pkg::MODE_RESET;
      pend_r   <= 1'b1;
      echo_r   <= 1'b0;
      dist_r   <= '0;
      count_r  <= '0;
      points_r <= '0;
      idle_r   <= '0;
      phase_r  <= 1'b0;
      div_r    <= '0;
      idp_r    <= 1'b0;
      up_r     <= '0;
      lamp_r   <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      echo_r   <= echo_nxt;
      dist_r   <= dist_nxt;
      count_r  <= count_nxt;
      points_r <= points_nxt;
      idle_r   <= idle_nxt;
      phase_r  <= phase_nxt;
      div_r    <= div_nxt;
      idp_r    <= idp_nxt;
      up_r     <= up_nxt;
      lamp_r   <= lamp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.mode_now        = res_r.mode_now;
  assign out_word.entry_action    = res_r.entry_action;
  assign out_word.launch_distance = res_r.launch_distance;
  assign out_word.lamp_on         = res_r.lamp_on;
  assign out_word.point_emitted   = res_r.point_emitted;
  assign out_word.point_number    = res_r.point_number;
  assign out_word.run_ended       = res_r.run_ended;
  assign out_word.identity_due    = res_r.identity_due;
  assign out_word.echo_ack        = res_r.echo_ack;
  assign out_word.request_taken   = res_r.request_taken;
  assign out_word.uptime_seconds  = res_r.uptime_seconds;

endmodule
`default_nettype wire
